// ===== sv/mbe_pkg.sv =====
// Shared constants, register codes and control types of the escape-time engine.
package mbe_pkg;

  // Fixed-point format and pixel coordinate width
  localparam int FRAC_BITS  = 26;
  localparam int COORD_BITS = 12;
  localparam int PIX_W      = 12;
  localparam int COORD_W    = (COORD_BITS < PIX_W) ? COORD_BITS : PIX_W;

  localparam int Z_W     = 32;
  localparam int STEP_W  = 31;
  localparam int ITER_W  = 16;
  localparam int PROD_W  = COORD_W + STEP_W;
  localparam int SQ_W    = 2 * Z_W;

  // Escape bound 4.0 at the scale of a square; no test when it does not fit
  localparam bit             NO_LIMIT  = (2 * FRAC_BITS + 2) >= SQ_W;
  localparam logic [SQ_W-1:0] MAG_BOUND = NO_LIMIT ? '0 :
                                          (SQ_W'(4) << (2 * FRAC_BITS));

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_RE_ORIGIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IM_ORIGIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RE_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IM_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 3'd4;

  localparam logic [Z_W-1:0]    RST_RE_ORIGIN = 32'hF600_0000;  // -2.5
  localparam logic [Z_W-1:0]    RST_IM_ORIGIN = 32'h0600_0000;  //  1.5
  localparam logic [STEP_W-1:0] RST_RE_STEP   = 31'd262400;
  localparam logic [STEP_W-1:0] RST_IM_STEP   = 31'd262486;
  localparam logic [ITER_W-1:0] RST_MAX_ITER  = 16'd10000;

  typedef struct packed {
    logic signed [Z_W-1:0] re_origin;
    logic signed [Z_W-1:0] im_origin;
    logic [STEP_W-1:0]     re_step;
    logic [STEP_W-1:0]     im_step;
    logic [ITER_W-1:0]     max_iter;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;   // take pixel, form step products, clear z
    logic calc_c;    // add origins to form c
    logic mul;       // register the three squares/products of z
    logic upd;       // advance z and the iteration count
    logic load_lim;  // write a limit result to the output register
    logic load_esc;  // write an escape result to the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic at_limit;
    logic escaped;
  } dp_sts_t;

endpackage

// ===== sv/mbe_if.sv =====
// Valid/ready channels for pixel items and result items.
interface mbe_pix_if;
  logic                     valid;
  logic                     ready;
  logic [mbe_pkg::PIX_W-1:0] pixel_col;
  logic [mbe_pkg::PIX_W-1:0] pixel_row;

  modport source (output valid, output pixel_col, output pixel_row, input ready);
  modport sink   (input valid, input pixel_col, input pixel_row, output ready);
endinterface

interface mbe_res_if;
  logic                      valid;
  logic                      ready;
  logic [mbe_pkg::ITER_W-1:0] escape_count;
  logic                      reached_limit;

  modport source (output valid, output escape_count, output reached_limit, input ready);
  modport sink   (input valid, input escape_count, input reached_limit, output ready);
endinterface

// ===== sv/mbe_ctrl.sv =====
// Sequencer of the escape-time engine: pixel intake, iteration loop, result hand-off.
module mbe_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  mbe_pkg::dp_sts_t sts_i,
  output mbe_pkg::dp_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CADD = 2'd1;
  localparam logic [1:0] ST_ITER = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_CADD;
        end
      end
      ST_CADD: begin
        cmd_o.calc_c = 1'b1;
        state_d      = ST_ITER;
      end
      ST_ITER: begin
        if (sts_i.at_limit) begin
          // hold until the output register is free
          if (out_free) begin
            cmd_o.load_lim = 1'b1;
            state_d        = ST_IDLE;
          end
        end else begin
          cmd_o.mul = 1'b1;
          state_d   = ST_UPD;
        end
      end
      ST_UPD: begin
        if (sts_i.escaped) begin
          if (out_free) begin
            cmd_o.load_esc = 1'b1;
            state_d        = ST_IDLE;
          end
        end else begin
          cmd_o.upd = 1'b1;
          state_d   = ST_ITER;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.load_lim || cmd_o.load_esc;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== sv/mbe_dp.sv =====
// Fixed-point datapath: point mapping, z = z*z + c, escape test and result register.
module mbe_dp (
  input  logic                       clk_i,
  input  mbe_pkg::cfg_t              cfg_i,
  input  logic [mbe_pkg::PIX_W-1:0]  pixel_col_i,
  input  logic [mbe_pkg::PIX_W-1:0]  pixel_row_i,
  input  mbe_pkg::dp_cmd_t           cmd_i,
  output mbe_pkg::dp_sts_t           sts_o,
  output logic [mbe_pkg::ITER_W-1:0] escape_count_o,
  output logic                       reached_limit_o
);

  logic [mbe_pkg::COORD_W-1:0] x, y;
  logic [mbe_pkg::PROD_W-1:0]  px_q, py_q;
  logic signed [mbe_pkg::Z_W-1:0]  cr_q, ci_q, zr_q, zi_q;
  logic signed [mbe_pkg::SQ_W-1:0] rr_q, ii_q, ri_q;
  logic [mbe_pkg::ITER_W-1:0]  it_q;
  logic [mbe_pkg::ITER_W-1:0]  cnt_q;
  logic                        lim_q;

  logic [mbe_pkg::SQ_W-1:0]        mag;
  logic signed [mbe_pkg::SQ_W-1:0] diff, re_sh, im_sh;
  logic signed [mbe_pkg::Z_W-1:0]  zr_d, zi_d;

  assign x = pixel_col_i[mbe_pkg::COORD_W-1:0];
  assign y = pixel_row_i[mbe_pkg::COORD_W-1:0];

  // |z|^2 from the registered squares; both are non-negative
  assign mag   = $unsigned(rr_q) + $unsigned(ii_q);
  assign diff  = rr_q - ii_q;
  assign re_sh = diff >>> mbe_pkg::FRAC_BITS;
  assign im_sh = ri_q >>> (mbe_pkg::FRAC_BITS - 1);
  assign zr_d  = re_sh[mbe_pkg::Z_W-1:0] + cr_q;
  assign zi_d  = im_sh[mbe_pkg::Z_W-1:0] + ci_q;

  assign sts_o.at_limit = it_q >= cfg_i.max_iter;
  assign sts_o.escaped  = !mbe_pkg::NO_LIMIT && (mag > mbe_pkg::MAG_BOUND);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      px_q <= x * cfg_i.re_step;
      py_q <= y * cfg_i.im_step;
      zr_q <= '0;
      zi_q <= '0;
      it_q <= '0;
    end
    if (cmd_i.calc_c) begin
      cr_q <= cfg_i.re_origin + px_q[mbe_pkg::Z_W-1:0];
      ci_q <= cfg_i.im_origin - py_q[mbe_pkg::Z_W-1:0];
    end
    if (cmd_i.mul) begin
      rr_q <= zr_q * zr_q;
      ii_q <= zi_q * zi_q;
      ri_q <= zr_q * zi_q;
    end
    if (cmd_i.upd) begin
      zr_q <= zr_d;
      zi_q <= zi_d;
      it_q <= it_q + 16'd1;
    end
    if (cmd_i.load_lim) begin
      cnt_q <= '0;
      lim_q <= 1'b1;
    end
    if (cmd_i.load_esc) begin
      cnt_q <= it_q;
      lim_q <= 1'b0;
    end
  end

  assign escape_count_o  = cnt_q;
  assign reached_limit_o = lim_q;

endmodule

// ===== sv/mandelbrot_escape_time_top.sv =====
// Mandelbrot escape-time engine: one pixel item in, one escape-count item out.
// Each pixel item (pixel_col, pixel_row) is mapped to c = (re_origin + x*re_step)
// + i*(im_origin - y*im_step) in signed Q6.26 and z = z*z + c is iterated from zero
// until |z|^2 exceeds 4.0 or the count reaches max_iterations. The result item gives
// the escape count, or 0 with reached_limit set when the limit was hit. One pixel is
// worked on at a time. Each iteration first registers the three 32x32 products of
// z, then does the escape compare and the z update. The finished result sits in an
// output register, so the next pixel is accepted while it waits; the engine stalls
// only when a second result is ready before the first is taken.
// Registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user must do so
// only while the engine is idle; the block does not enforce it. Indexes 0..4 are
// re_origin, im_origin, re_step, im_step, max_iterations; other indexes are dropped.
module mandelbrot_escape_time_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  mbe_pix_if.sink                        pix_i,
  mbe_res_if.source                      res_o,
  input  logic                           cfg_we_i,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mbe_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  mbe_pkg::cfg_t    cfg_q;
  mbe_pkg::dp_cmd_t cmd;
  mbe_pkg::dp_sts_t sts;

  // Configuration registers; narrower registers keep the low bits of the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.re_origin <= mbe_pkg::RST_RE_ORIGIN;
      cfg_q.im_origin <= mbe_pkg::RST_IM_ORIGIN;
      cfg_q.re_step   <= mbe_pkg::RST_RE_STEP;
      cfg_q.im_step   <= mbe_pkg::RST_IM_STEP;
      cfg_q.max_iter  <= mbe_pkg::RST_MAX_ITER;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mbe_pkg::CFG_RE_ORIGIN: cfg_q.re_origin <= cfg_wdata_i[mbe_pkg::Z_W-1:0];
        mbe_pkg::CFG_IM_ORIGIN: cfg_q.im_origin <= cfg_wdata_i[mbe_pkg::Z_W-1:0];
        mbe_pkg::CFG_RE_STEP:   cfg_q.re_step   <= cfg_wdata_i[mbe_pkg::STEP_W-1:0];
        mbe_pkg::CFG_IM_STEP:   cfg_q.im_step   <= cfg_wdata_i[mbe_pkg::STEP_W-1:0];
        mbe_pkg::CFG_MAX_ITER:  cfg_q.max_iter  <= cfg_wdata_i[mbe_pkg::ITER_W-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Sequencer: owns the handshakes and the result valid flag
  mbe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Arithmetic and the result payload register
  mbe_dp u_dp (
    .clk_i           (clk_i),
    .cfg_i           (cfg_q),
    .pixel_col_i     (pix_i.pixel_col),
    .pixel_row_i     (pix_i.pixel_row),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .escape_count_o  (res_o.escape_count),
    .reached_limit_o (res_o.reached_limit)
  );

`ifndef SYNTH
  // One pixel at a time: no accept right after an accept
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_i.valid && pix_i.ready) |=> !pix_i.ready)
    else $error("pixel accepted while previous pixel still in work");

  // A limit result always carries a zero count
  a_limit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.reached_limit) |-> (res_o.escape_count == '0))
    else $error("limit result with nonzero count");

  // An escape count stays below the iteration limit
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.reached_limit) |-> (res_o.escape_count < cfg_q.max_iter))
    else $error("escape count at or above the limit");
`endif

endmodule

// ===== verif/mandelbrot_escape_time_top_tb.sv =====
// Self-checking testbench for the Mandelbrot escape-time engine.
`timescale 1ns / 1ps

module mandelbrot_escape_time_top_tb;
  import mbe_pkg::*;

  // Longest correct quiet stretch is one pixel at the full 16-bit limit.
  // Allow several times that before giving up.
  localparam int WATCHDOG_LIMIT = 600_000;
  localparam int REPORT_MAX     = 10;
  localparam int SETTLE_CYCLES  = 20;
  localparam int Q_ONE          = 1 << FRAC_BITS;   // 1.0 in the coordinate format
  localparam int HALF_SPAN      = 1 << (PIX_W - 1); // pixel index at the middle of a frame

  typedef struct packed {
    logic [PIX_W-1:0] col;
    logic [PIX_W-1:0] row;
  } pixel_t;

  typedef struct packed {
    pixel_t            pix;
    logic [ITER_W-1:0] count;
    logic              at_limit;
  } escape_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  mbe_pix_if pix_if ();
  mbe_res_if res_if ();

  // Shadow of the engine's registers, kept in step with every write
  cfg_t        view_cfg;
  pixel_t      pending_pixels[$];
  escape_t     expected_escapes[$];
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned mismatch_cnt;
  int unsigned quiet_cycles;

  mandelbrot_escape_time_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_i       (pix_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Escape-time prediction for one pixel under the current register view.
  // Squares are kept at full 64-bit width; z and c wrap to 32 bits.
  function automatic escape_t escape_time(input logic [PIX_W-1:0] col,
                                          input logic [PIX_W-1:0] row);
    bit [63:0]          x, y, mag, bound;
    bit                 unbounded;
    logic signed [31:0] cr, ci, zr, zi;
    longint             rr, ii, nr, ni;
    int unsigned        iters;
    escape_t            res;
    x         = 64'(col) & ((64'd1 << COORD_BITS) - 1);
    y         = 64'(row) & ((64'd1 << COORD_BITS) - 1);
    cr        = 32'(64'(view_cfg.re_origin) + x * 64'(view_cfg.re_step));
    ci        = 32'(64'(view_cfg.im_origin) - y * 64'(view_cfg.im_step));
    unbounded = (2 * FRAC_BITS + 2) >= 64;
    bound     = unbounded ? 64'd0 : (64'd4 << (2 * FRAC_BITS));
    zr        = '0;
    zi        = '0;
    iters     = 0;
    while (iters < view_cfg.max_iter) begin
      rr  = longint'(zr) * longint'(zr);
      ii  = longint'(zi) * longint'(zi);
      mag = unsigned'(rr) + unsigned'(ii);
      if (!unbounded && mag > bound) break;
      // arithmetic shifts of signed values round toward minus infinity
      nr = (rr - ii) >>> FRAC_BITS;
      ni = (longint'(zr) * longint'(zi)) >>> (FRAC_BITS - 1);
      zr = 32'(nr + longint'(cr));
      zi = 32'(ni + longint'(ci));
      iters++;
    end
    res.pix.col = col;
    res.pix.row = row;
    if (iters >= view_cfg.max_iter) begin
      res.count    = '0;
      res.at_limit = 1'b1;
    end else begin
      res.count    = ITER_W'(iters);
      res.at_limit = 1'b0;
    end
    return res;
  endfunction

  // Drive one register write and mirror it; indexes outside the map are dropped
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_RE_ORIGIN: view_cfg.re_origin = data[Z_W-1:0];
      CFG_IM_ORIGIN: view_cfg.im_origin = data[Z_W-1:0];
      CFG_RE_STEP:   view_cfg.re_step   = data[STEP_W-1:0];
      CFG_IM_STEP:   view_cfg.im_step   = data[STEP_W-1:0];
      CFG_MAX_ITER:  view_cfg.max_iter  = data[ITER_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_view(input logic [CFG_DATA_W-1:0] re_org, input logic [CFG_DATA_W-1:0] im_org,
                          input logic [CFG_DATA_W-1:0] re_stp, input logic [CFG_DATA_W-1:0] im_stp,
                          input logic [CFG_DATA_W-1:0] iters);
    write_reg(CFG_RE_ORIGIN, re_org);
    write_reg(CFG_IM_ORIGIN, im_org);
    write_reg(CFG_RE_STEP, re_stp);
    write_reg(CFG_IM_STEP, im_stp);
    write_reg(CFG_MAX_ITER, iters);
  endtask

  // Drop the write enable and step off the edge before queuing new items
  task automatic close_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Hold until every queued item is taken and every expected result is back
  task automatic drain();
    do @(negedge clk_i);
    while (pending_pixels.size() != 0 || pix_if.valid || expected_escapes.size() != 0);
  endtask

  task automatic queue_pixel(input int unsigned col, input int unsigned row);
    pixel_t p;
    p.col = PIX_W'(col);
    p.row = PIX_W'(row);
    pending_pixels.push_back(p);
  endtask

  task automatic queue_random(input int n);
    repeat (n) queue_pixel($urandom_range((1 << PIX_W) - 1), $urandom_range((1 << PIX_W) - 1));
  endtask

  // Mostly frame a window over the set so points iterate for a while;
  // now and then throw fully random registers at it.
  task automatic random_view();
    int unsigned       step_re, step_im;
    int                center_re, center_im;
    logic [ITER_W-1:0] iters;
    iters = ($urandom_range(3) == 0) ? ITER_W'($urandom_range(1000, 257))
                                     : ITER_W'($urandom_range(256, 1));
    if ($urandom_range(3) != 0) begin
      step_re   = $urandom_range(70000, 16);
      step_im   = $urandom_range(70000, 16);
      center_re = int'($urandom_range(5 * Q_ONE / 2)) - 2 * Q_ONE;
      center_im = int'($urandom_range(12 * Q_ONE / 5)) - 6 * Q_ONE / 5;
      set_view(center_re - HALF_SPAN * int'(step_re), center_im + HALF_SPAN * int'(step_im),
               step_re, step_im, iters);
    end else begin
      set_view($urandom, $urandom, $urandom, $urandom, iters);
    end
  endtask

  task automatic run_random_phase(input int unsigned send_pct, input int unsigned res_pct,
                                  input bit mid_pause);
    send_idle_pct = send_pct;
    stall_pct     = res_pct;
    repeat (2) begin
      random_view();
      close_writes();
      queue_random(5);
      // optionally let the engine run dry with the same registers
      if (mid_pause) drain();
      queue_random(5);
      drain();
    end
  endtask

  // Pixel driver: advance to the next pending item once the current one is taken
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t nxt;
    if (!rst_ni) begin
      pix_if.valid     <= 1'b0;
      pix_if.pixel_col <= '0;
      pix_if.pixel_row <= '0;
    end else if (!pix_if.valid || pix_if.ready) begin
      if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_pixels.pop_front();
        pix_if.valid     <= 1'b1;
        pix_if.pixel_col <= nxt.col;
        pix_if.pixel_row <= nxt.row;
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver: stall at random per the current phase
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Predict on every accepted pixel item
  always @(posedge clk_i) begin
    if (rst_ni && pix_if.valid && pix_if.ready)
      expected_escapes.push_back(escape_time(pix_if.pixel_col, pix_if.pixel_row));
  end

  // Check every accepted result item against the oldest prediction
  always @(posedge clk_i) begin
    escape_t exp_esc;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_escapes.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $display("unexpected result item: count %0d at_limit %0b",
                   res_if.escape_count, res_if.reached_limit);
      end else begin
        exp_esc = expected_escapes.pop_front();
        if (res_if.escape_count !== exp_esc.count ||
            res_if.reached_limit !== exp_esc.at_limit) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX)
            $display({"mismatch at pixel (%0d,%0d): expected count %0d at_limit %0b, ",
                      "got count %0d at_limit %0b"},
                     exp_esc.pix.col, exp_esc.pix.row, exp_esc.count, exp_esc.at_limit,
                     res_if.escape_count, res_if.reached_limit);
        end
      end
    end
  end

  // Watchdog: count cycles with no item moving on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // Every input known from time zero
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_RE_ORIGIN;
    cfg_wdata_i      = '0;
    pix_if.valid     = 1'b0;
    pix_if.pixel_col = '0;
    pix_if.pixel_row = '0;
    res_if.ready     = 1'b0;
    send_idle_pct    = 0;
    stall_pct        = 0;
    mismatch_cnt     = 0;
    quiet_cycles     = 0;

    view_cfg.re_origin = RST_RE_ORIGIN;
    view_cfg.im_origin = RST_IM_ORIGIN;
    view_cfg.re_step   = RST_RE_STEP;
    view_cfg.im_step   = RST_IM_STEP;
    view_cfg.max_iter  = RST_MAX_ITER;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset view: frame corners, then two points inside the set that run
    // the full default limit (near the origin and near -0.5).
    queue_pixel(0, 0);
    queue_pixel((1 << PIX_W) - 1, (1 << PIX_W) - 1);
    queue_pixel((1 << PIX_W) - 1, 0);
    queue_pixel(0, (1 << PIX_W) - 1);
    queue_pixel(640, 384);
    queue_pixel(512, 384);
    drain();

    // Unit grid at the origin. c = 2 first fails the escape test at count 2,
    // so with a limit of 2 it must be reported as reaching the limit.
    // Writes to unmapped indexes must leave this view alone.
    set_view(0, 0, Q_ONE, Q_ONE, 2);
    for (int i = int'(CFG_MAX_ITER) + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), $urandom);
    close_writes();
    queue_pixel(2, 0);
    queue_pixel(0, 0);
    drain();

    // Same grid, one more iteration allowed: now c = 2 and c = -2i escape
    set_view(0, 0, Q_ONE, Q_ONE, 3);
    close_writes();
    queue_pixel(2, 0);
    queue_pixel(0, 2);
    queue_pixel(3, 0);
    drain();

    // Zero limit: no iteration runs, every point is at the limit
    write_reg(CFG_MAX_ITER, 0);
    close_writes();
    queue_pixel(0, 0);
    queue_pixel((1 << PIX_W) - 1, (1 << PIX_W) - 1);
    drain();

    // Register extremes with wrapping c; upper bits of the narrow registers
    // are set on the bus. Pixel (1,1) wraps back to c near zero and runs
    // the full 16-bit limit.
    set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    close_writes();
    queue_pixel(0, 0);
    queue_pixel((1 << PIX_W) - 1, (1 << PIX_W) - 1);
    queue_pixel(2, 2);
    queue_pixel(1, 1);
    drain();

    // Opposite extremes, zero steps, single iteration
    set_view(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 1);
    close_writes();
    queue_pixel(0, 0);
    queue_pixel((1 << PIX_W) - 1, (1 << PIX_W) - 1);
    queue_pixel((1 << PIX_W) - 1, 0);
    drain();

    // Random views under each idling pattern
    run_random_phase(0, 0, 1'b0);
    run_random_phase(75, 0, 1'b0);
    run_random_phase(0, 75, 1'b0);
    run_random_phase(9, 9, 1'b1);

    // Give a late or duplicate result the chance to show up
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_escapes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/mbe_pkg.sv
sv/mbe_if.sv
sv/mbe_ctrl.sv
sv/mbe_dp.sv
sv/mandelbrot_escape_time_top.sv
verif/mandelbrot_escape_time_top_tb.sv
